>>> hw/rtl/ppmm_pkg.sv
`timescale 1ns / 1ps

package ppmm_pkg;

  // Sizing of the mailbox array.
  localparam int NUM_PROCS  = 64;
  localparam int RING_SLOTS = 32;

  // Field widths of the request and the response.
  localparam int PID_W   = 6;
  localparam int WORD_W  = 32;
  localparam int MASK_W  = 64;
  localparam int STAT_W  = 2;

  // Derived storage widths.
  localparam int PROC_AW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int IDX_W    = $clog2(RING_SLOTS);
  localparam int STORE_D  = NUM_PROCS * RING_SLOTS;
  localparam int STORE_AW = $clog2(STORE_D);
  localparam int ENTRY_W  = 4 * WORD_W;

  // Request codes.
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  // Response status codes.
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;        // latch the request and read its index pair
    logic look_commit;   // finish a request that needs no store read
    logic fetch;         // advance the read index and read the store
    logic fetch_commit;  // finish a receive with the fetched entry
  } ppmm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fetch;    // the request is a receive on a non-empty queue
  } ppmm_stat_t;

endpackage

>>> hw/rtl/ppmm_in_if.sv
`timescale 1ns / 1ps

interface ppmm_in_if import ppmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [PID_W-1:0]  pid;
  logic [WORD_W-1:0] msg_code;
  logic [WORD_W-1:0] wparam_in;
  logic [WORD_W-1:0] lparam_in;
  logic [WORD_W-1:0] now_tick;

  modport source (
    output valid, cmd, pid, msg_code, wparam_in, lparam_in, now_tick,
    input  ready
  );

  modport sink (
    input  valid, cmd, pid, msg_code, wparam_in, lparam_in, now_tick,
    output ready
  );
endinterface

>>> hw/rtl/ppmm_out_if.sv
`timescale 1ns / 1ps

interface ppmm_out_if import ppmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              wake_receiver;
  logic              dropped_oldest;
  logic [WORD_W-1:0] msg_out;
  logic [WORD_W-1:0] wparam_out;
  logic [WORD_W-1:0] lparam_out;
  logic [WORD_W-1:0] time_out;

  modport source (
    output valid, status, wake_receiver, dropped_oldest,
           msg_out, wparam_out, lparam_out, time_out,
    input  ready
  );

  modport sink (
    input  valid, status, wake_receiver, dropped_oldest,
           msg_out, wparam_out, lparam_out, time_out,
    output ready
  );
endinterface

>>> hw/rtl/per_process_message_mailbox.sv
`timescale 1ns / 1ps

// Channel    Dir   Handshake        Contents
// in_req     in    valid / ready    cmd, pid, msg_code, wparam_in, lparam_in, now_tick
// out_rsp    out   valid / ready    status, wake_receiver, dropped_oldest, msg_out,
//                                   wparam_out, lparam_out, time_out
// cfg        in    cfg_we           cfg_wdata: process present mask
//
// A send, a rejected send and an empty receive pass the accept and look steps; a
// receive that returns a message adds a fetch step, because the store address
// depends on the read index, which comes out of the registered index RAM.
// Reset clears the present mask, the controller and one valid bit per process
// for the index pairs; no clearing pass is needed and the message store is not
// cleared. A waiting response sits in the output register while the next
// request is taken; a request only stalls at its commit step when the output
// register is still full.

module per_process_message_mailbox import ppmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ppmm_in_if.sink           in_req,
  ppmm_out_if.source        out_rsp,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata
);

  ppmm_cmd_t  ctrl_cmd;
  ppmm_stat_t dp_stat;

  // The controller sequences each request: look up the index pair, then
  // either commit the result or fetch the stored entry first.
  ppmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  // The datapath holds the mask, the per-process ring indices, the message
  // store and the output register.
  ppmm_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctrl_cmd),
    .stat        (dp_stat),
    .in_cmd      (in_req.cmd),
    .in_pid      (in_req.pid),
    .in_msg_code (in_req.msg_code),
    .in_wparam   (in_req.wparam_in),
    .in_lparam   (in_req.lparam_in),
    .in_now_tick (in_req.now_tick),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_status  (out_rsp.status),
    .out_wake    (out_rsp.wake_receiver),
    .out_dropped (out_rsp.dropped_oldest),
    .out_msg     (out_rsp.msg_out),
    .out_wparam  (out_rsp.wparam_out),
    .out_lparam  (out_rsp.lparam_out),
    .out_time    (out_rsp.time_out)
  );

  // Once a request is taken, the block is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted in two consecutive cycles");

  // A response never appears in the cycle right after a request is taken.
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> !$past(in_req.valid && in_req.ready))
    else $error("response raised too soon after a request");

  // A store fetch is always followed by a cycle where no new request enters.
  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.fetch |=> !in_req.ready && !ctrl_cmd.look_commit)
    else $error("fetch step not followed by its commit step");

endmodule

>>> hw/rtl/ppmm_ram.sv
`timescale 1ns / 1ps

module ppmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ppmm_ctrl.sv
`timescale 1ns / 1ps

module ppmm_ctrl import ppmm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ppmm_stat_t stat,
  output ppmm_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FETCH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new response when empty or draining now.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.need_fetch) begin
          cmd.fetch = 1'b1;
          state_nxt = S_FETCH;
        end else if (out_free) begin
          cmd.look_commit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_FETCH: begin
        if (out_free) begin
          cmd.fetch_commit = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.look_commit || cmd.fetch_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/ppmm_datapath.sv
`timescale 1ns / 1ps

module ppmm_datapath import ppmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ppmm_cmd_t         cmd,
  output ppmm_stat_t        stat,
  input  logic              in_cmd,
  input  logic [PID_W-1:0]  in_pid,
  input  logic [WORD_W-1:0] in_msg_code,
  input  logic [WORD_W-1:0] in_wparam,
  input  logic [WORD_W-1:0] in_lparam,
  input  logic [WORD_W-1:0] in_now_tick,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata,
  output logic [STAT_W-1:0] out_status,
  output logic              out_wake,
  output logic              out_dropped,
  output logic [WORD_W-1:0] out_msg,
  output logic [WORD_W-1:0] out_wparam,
  output logic [WORD_W-1:0] out_lparam,
  output logic [WORD_W-1:0] out_time
);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [STORE_AW-1:0] store_addr(input logic [PROC_AW-1:0] p,
                                                     input logic [IDX_W-1:0]   s);
    return STORE_AW'(int'(p) * RING_SLOTS + int'(s));
  endfunction

  logic [MASK_W-1:0]    mask_r;
  logic [NUM_PROCS-1:0] idx_vld_r;
  logic                 req_cmd_r;
  logic [PID_W-1:0]     pid_r;
  logic [WORD_W-1:0]    code_r, wp_r, lp_r, tick_r;

  logic [PROC_AW-1:0]   pid_idx;
  logic [2*IDX_W-1:0]   idx_rdata, idx_wdata;
  logic                 idx_we;
  logic [IDX_W-1:0]     rd_cur, wr_cur, wr_nxt;
  logic                 pid_ok, present, snd_reject, q_empty, q_full;
  logic                 is_send;
  logic                 store_we;
  logic [ENTRY_W-1:0]   store_rdata;

  assign pid_idx = pid_r[PROC_AW-1:0];
  assign is_send = (req_cmd_r == CMD_SEND);

  // Index pairs that were never written read as zero.
  assign rd_cur = idx_vld_r[pid_idx] ? idx_rdata[2*IDX_W-1:IDX_W] : '0;
  assign wr_cur = idx_vld_r[pid_idx] ? idx_rdata[IDX_W-1:0] : '0;
  assign wr_nxt = ring_next(wr_cur);

  assign pid_ok     = ({1'b0, pid_r} < (PID_W + 1)'(NUM_PROCS));
  assign present    = pid_ok && mask_r[pid_r];
  assign snd_reject = (pid_r == '0) || !present;
  assign q_empty    = (rd_cur == wr_cur);
  assign q_full     = (rd_cur == wr_nxt);

  assign stat.need_fetch = !is_send && pid_ok && !q_empty;

  assign store_we = cmd.look_commit && is_send && !snd_reject;
  assign idx_we   = store_we || cmd.fetch;

  always_comb begin
    if (is_send) begin
      idx_wdata = {(q_full ? ring_next(rd_cur) : rd_cur), wr_nxt};
    end else begin
      idx_wdata = {ring_next(rd_cur), wr_cur};
    end
  end

  ppmm_ram #(
    .WIDTH (2 * IDX_W),
    .DEPTH (NUM_PROCS)
  ) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (pid_idx),
    .wdata (idx_wdata),
    .re    (cmd.accept),
    .raddr (in_pid[PROC_AW-1:0]),
    .rdata (idx_rdata)
  );

  ppmm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_D)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr(pid_idx, wr_nxt)),
    .wdata ({code_r, wp_r, lp_r, tick_r}),
    .re    (cmd.fetch),
    .raddr (store_addr(pid_idx, ring_next(rd_cur))),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      idx_vld_r <= '0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (idx_we) begin
        idx_vld_r[pid_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_cmd_r <= in_cmd;
      pid_r     <= in_pid;
      code_r    <= in_msg_code;
      wp_r      <= in_wparam;
      lp_r      <= in_lparam;
      tick_r    <= in_now_tick;
    end
    if (cmd.look_commit) begin
      if (is_send) begin
        out_status <= snd_reject ? ST_REJECT : ST_DONE;
      end else begin
        out_status <= ST_EMPTY;
      end
      out_wake    <= is_send && !snd_reject && q_empty;
      out_dropped <= is_send && !snd_reject && !q_empty && q_full;
      out_msg     <= '0;
      out_wparam  <= '0;
      out_lparam  <= '0;
      out_time    <= '0;
    end else if (cmd.fetch_commit) begin
      out_status  <= ST_DONE;
      out_wake    <= 1'b0;
      out_dropped <= 1'b0;
      out_msg     <= store_rdata[4*WORD_W-1:3*WORD_W];
      out_wparam  <= store_rdata[3*WORD_W-1:2*WORD_W];
      out_lparam  <= store_rdata[2*WORD_W-1:WORD_W];
      out_time    <= store_rdata[WORD_W-1:0];
    end
  end

endmodule
